FILE: rtl/plcs_pkg.sv
// ----------------------------------------------------------------------------
// plcs_pkg
// Shared types, constants and codes for the polyline line crossing block.
// ----------------------------------------------------------------------------
`default_nettype none

package plcs_pkg;

	localparam int MAX_HITS_DEF    = 32;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FIELD_W         = 32;
	localparam int CFG_IDX_W       = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CUT_START_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CUT_START_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CUT_END_X   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CUT_END_Y   = 2'd3;

	typedef struct packed {
		logic [FIELD_W-1:0] vertex_x;
		logic [FIELD_W-1:0] vertex_y;
		logic               final_vertex;
	} vtx_t;

	typedef struct packed {
		logic [FIELD_W-1:0] hit_x;
		logic [FIELD_W-1:0] hit_y;
		logic               last_hit;
		logic               none_found;
		logic               hits_dropped;
	} hit_t;

	// multiplier operations, each names the product and where it accumulates
	typedef enum logic [2:0] {
		MOP_DEN_A = 3'd0,  // den  = dy2*dx1
		MOP_DEN_B = 3'd1,  // den -= dx2*dy1
		MOP_NA_A  = 3'd2,  // na   = dx2*oy
		MOP_NA_B  = 3'd3,  // na  -= dy2*ox
		MOP_NB_A  = 3'd4,  // nb   = dx1*oy
		MOP_NB_B  = 3'd5,  // nb  -= dy1*ox
		MOP_SC_LO = 3'd6,  // acc  = na_lo*mag
		MOP_SC_HI = 3'd7   // acc += na_hi*mag << QW
	} mop_t;

	typedef struct packed {
		logic in_ready;
		logic mul_go;
		mop_t mul_op;
		logic norm;
		logic div_load;
		logic div_step;
		logic add;
		logic axis;
		logic ins;
		logic fin;
		logic emit_load;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic have_prev;
		logic final_vertex;
		logic seg_hit;
		logic out_free;
		logic emit_last;
	} sts_t;

endpackage

`default_nettype wire

FILE: rtl/plcs_vtx_if.sv
// ----------------------------------------------------------------------------
// plcs_vtx_if
// Vertex channel: valid/ready handshake with a vertex payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface plcs_vtx_if;
	logic           valid;
	logic           ready;
	plcs_pkg::vtx_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/plcs_hit_if.sv
// ----------------------------------------------------------------------------
// plcs_hit_if
// Result channel: valid/ready handshake with a hit payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface plcs_hit_if;
	logic           valid;
	logic           ready;
	plcs_pkg::hit_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/plcs_ctrl.sv
// ----------------------------------------------------------------------------
// plcs_ctrl
// Sequencer: steps the datapath through products, division, insert and emit.
// ----------------------------------------------------------------------------
`default_nettype none

module plcs_ctrl #(
	parameter int COORD_WIDTH = plcs_pkg::COORD_WIDTH_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  plcs_pkg::sts_t  sts,
	output plcs_pkg::cmd_t  cmd
);

	localparam int QW  = COORD_WIDTH + 1;
	localparam int CTW = $clog2(QW + 1);

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_MUL  = 10'b0000000010,
		S_NORM = 10'b0000000100,
		S_CHK  = 10'b0000001000,
		S_SMUL = 10'b0000010000,
		S_DIV  = 10'b0000100000,
		S_ADD  = 10'b0001000000,
		S_INS  = 10'b0010000000,
		S_FIN  = 10'b0100000000,
		S_EMIT = 10'b1000000000
	} state_t;

	state_t           state_q, state_d;
	logic [CTW-1:0]   cnt_q, cnt_d;
	logic             axis_q, axis_d;

	always_comb begin
		cmd      = '0;
		cmd.axis = axis_q;
		state_d  = state_q;
		cnt_d    = cnt_q;
		axis_d   = axis_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				cnt_d        = '0;
				if (sts.in_valid) begin
					state_d = sts.have_prev ? S_MUL : S_FIN;
				end
			end
			S_MUL: begin
				if (cnt_q < CTW'(6)) begin
					cmd.mul_go = 1'b1;
					cmd.mul_op = plcs_pkg::mop_t'(cnt_q[2:0]);
				end
				if (cnt_q == CTW'(6)) begin
					cnt_d   = '0;
					state_d = S_NORM;
				end else begin
					cnt_d = cnt_q + CTW'(1);
				end
			end
			S_NORM: begin
				cmd.norm = 1'b1;
				state_d  = S_CHK;
			end
			S_CHK: begin
				axis_d  = 1'b0;
				cnt_d   = '0;
				state_d = sts.seg_hit ? S_SMUL : S_FIN;
			end
			S_SMUL: begin
				if (cnt_q == CTW'(0)) begin
					cmd.mul_go = 1'b1;
					cmd.mul_op = plcs_pkg::MOP_SC_LO;
				end else if (cnt_q == CTW'(1)) begin
					cmd.mul_go = 1'b1;
					cmd.mul_op = plcs_pkg::MOP_SC_HI;
				end
				if (cnt_q == CTW'(2)) begin
					cnt_d   = '0;
					state_d = S_DIV;
				end else begin
					cnt_d = cnt_q + CTW'(1);
				end
			end
			S_DIV: begin
				if (cnt_q == CTW'(0)) begin
					cmd.div_load = 1'b1;
				end else begin
					cmd.div_step = 1'b1;
				end
				if (cnt_q == CTW'(QW)) begin
					cnt_d   = '0;
					state_d = S_ADD;
				end else begin
					cnt_d = cnt_q + CTW'(1);
				end
			end
			S_ADD: begin
				cmd.add = 1'b1;
				if (!axis_q) begin
					axis_d  = 1'b1;
					state_d = S_SMUL;
				end else begin
					state_d = S_INS;
				end
			end
			S_INS: begin
				cmd.ins = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = sts.final_vertex ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_load = 1'b1;
					if (sts.emit_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			axis_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			axis_q  <= axis_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/plcs_dp.sv
// ----------------------------------------------------------------------------
// plcs_dp
// Datapath: cut registers, vertex hold, multiplier, divider, sorted hit store
// and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module plcs_dp #(
	parameter int MAX_HITS    = plcs_pkg::MAX_HITS_DEF,
	parameter int COORD_WIDTH = plcs_pkg::COORD_WIDTH_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_we,
	input  wire [plcs_pkg::CFG_IDX_W-1:0]         cfg_idx,
	input  wire [plcs_pkg::FIELD_W-1:0]           cfg_data,
	input  plcs_pkg::cmd_t                        cmd,
	output plcs_pkg::sts_t                        sts,
	plcs_vtx_if.sink                              vtx,
	plcs_hit_if.source                            hit
);

	localparam int CW  = COORD_WIDTH;
	localparam int D1  = CW + 1;
	localparam int MW  = CW + 3;
	localparam int NW  = 2 * CW + 4;
	localparam int QW  = CW + 1;
	localparam int PW  = NW + QW;
	localparam int CNW = $clog2(MAX_HITS + 1);
	localparam int IW  = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
	localparam int FW  = plcs_pkg::FIELD_W;

	// configuration
	logic [CW-1:0] cx_q, cy_q, ex_q, ey_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			ex_q <= '0;
			ey_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				plcs_pkg::REG_CUT_START_X: cx_q <= cfg_data[CW-1:0];
				plcs_pkg::REG_CUT_START_Y: cy_q <= cfg_data[CW-1:0];
				plcs_pkg::REG_CUT_END_X:   ex_q <= cfg_data[CW-1:0];
				plcs_pkg::REG_CUT_END_Y:   ey_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// vertex hold
	logic [CW-1:0] cur_x_q, cur_y_q, prev_x_q, prev_y_q;
	logic          fin_q, have_prev_q;
	logic          in_xfer;

	assign vtx.ready = cmd.in_ready;
	assign in_xfer   = vtx.valid && cmd.in_ready;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cur_x_q <= vtx.data.vertex_x[CW-1:0];
			cur_y_q <= vtx.data.vertex_y[CW-1:0];
		end
	end

	// differences, CW+1 bits signed
	function automatic logic signed [D1-1:0] dif(input logic [CW-1:0] a, input logic [CW-1:0] b);
		dif = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
	endfunction

	logic signed [D1-1:0] dx1, dy1, dx2, dy2, ox, oy, delta;
	logic [D1-1:0]        mag;
	logic                 dneg;

	assign dx1   = dif(cur_x_q, prev_x_q);
	assign dy1   = dif(cur_y_q, prev_y_q);
	assign dx2   = dif(ex_q, cx_q);
	assign dy2   = dif(ey_q, cy_q);
	assign ox    = dif(prev_x_q, cx_q);
	assign oy    = dif(prev_y_q, cy_q);
	assign delta = cmd.axis ? dy1 : dx1;
	assign dneg  = delta[D1-1];
	assign mag   = dneg ? D1'(-delta) : D1'(delta);

	// multiplier, one product per cycle, registered
	logic signed [NW-1:0]   den_q, na_q, nb_q;
	logic signed [MW-1:0]   ma, mb;
	logic signed [2*MW-1:0] prod_s1;
	logic                   vld_s1;
	plcs_pkg::mop_t         op_s1;

	function automatic logic signed [MW-1:0] ext(input logic signed [D1-1:0] v);
		ext = {{(MW-D1){v[D1-1]}}, v};
	endfunction

	always_comb begin
		ma = ext(dy2);
		mb = ext(dx1);
		case (cmd.mul_op)
			plcs_pkg::MOP_DEN_A: begin ma = ext(dy2); mb = ext(dx1); end
			plcs_pkg::MOP_DEN_B: begin ma = ext(dx2); mb = ext(dy1); end
			plcs_pkg::MOP_NA_A:  begin ma = ext(dx2); mb = ext(oy);  end
			plcs_pkg::MOP_NA_B:  begin ma = ext(dy2); mb = ext(ox);  end
			plcs_pkg::MOP_NB_A:  begin ma = ext(dx1); mb = ext(oy);  end
			plcs_pkg::MOP_NB_B:  begin ma = ext(dy1); mb = ext(ox);  end
			plcs_pkg::MOP_SC_LO: begin
				ma = $signed({{(MW-QW){1'b0}}, na_q[QW-1:0]});
				mb = $signed({{(MW-D1){1'b0}}, mag});
			end
			plcs_pkg::MOP_SC_HI: begin
				ma = $signed({{(MW-(NW-1-QW)){1'b0}}, na_q[NW-2:QW]});
				mb = $signed({{(MW-D1){1'b0}}, mag});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.mul_go;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			prod_s1 <= ma * mb;
			op_s1   <= cmd.mul_op;
		end
	end

	// accumulate products, normalize sign of the denominator
	logic [PW-1:0]        acc_q;
	logic signed [NW-1:0] pn;
	logic [PW-1:0]        pw;

	assign pn = prod_s1[NW-1:0];
	assign pw = {{(PW-2*MW){1'b0}}, prod_s1};

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			case (op_s1)
				plcs_pkg::MOP_DEN_A: den_q <= pn;
				plcs_pkg::MOP_DEN_B: den_q <= den_q - pn;
				plcs_pkg::MOP_NA_A:  na_q  <= pn;
				plcs_pkg::MOP_NA_B:  na_q  <= na_q - pn;
				plcs_pkg::MOP_NB_A:  nb_q  <= pn;
				plcs_pkg::MOP_NB_B:  nb_q  <= nb_q - pn;
				plcs_pkg::MOP_SC_LO: acc_q <= pw;
				plcs_pkg::MOP_SC_HI: acc_q <= acc_q + (pw << QW);
				default: ;
			endcase
		end else if (cmd.norm && den_q[NW-1]) begin
			den_q <= -den_q;
			na_q  <= -na_q;
			nb_q  <= -nb_q;
		end
	end

	logic [NW-1:0] dma, dmb;
	assign dma = den_q - na_q;
	assign dmb = den_q - nb_q;
	assign sts.seg_hit = (den_q != '0) && !na_q[NW-1] && !nb_q[NW-1]
		&& !dma[NW-1] && !dmb[NW-1];

	// restoring divider, one quotient bit per cycle; quotient shifts into lo_q
	logic [NW-1:0] r_q;
	logic [QW-1:0] lo_q;
	logic [NW:0]   r2, rd;

	assign r2 = {r_q, lo_q[QW-1]};
	assign rd = r2 - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			r_q  <= acc_q[PW-1:QW];
			lo_q <= acc_q[QW-1:0];
		end else if (cmd.div_step) begin
			if (!rd[NW]) begin
				r_q <= rd[NW-1:0];
			end else begin
				r_q <= r2[NW-1:0];
			end
			lo_q <= {lo_q[QW-2:0], !rd[NW]};
		end
	end

	// hit point: previous vertex plus signed offset
	logic [CW-1:0]        hx_q, hy_q, base;
	logic signed [QW:0]   off;
	logic [QW:0]          sum;

	assign base = cmd.axis ? prev_y_q : prev_x_q;
	assign off  = dneg ? -$signed({1'b0, lo_q}) : $signed({1'b0, lo_q});
	assign sum  = {{(QW+1-CW){base[CW-1]}}, base} + off;

	always_ff @(posedge clk) begin
		if (cmd.add) begin
			if (cmd.axis) begin
				hy_q <= sum[CW-1:0];
			end else begin
				hx_q <= sum[CW-1:0];
			end
		end
	end

	// sorted store: each entry takes its left neighbor, the new hit, or holds
	logic [CW-1:0]  st_x [MAX_HITS];
	logic [CW-1:0]  st_y [MAX_HITS];
	logic [CNW-1:0] count_q;
	logic           ovf_q;
	logic [IW-1:0]  rd_q;
	logic           gt [MAX_HITS];
	logic           full;
	logic           emit_fire;

	assign full = (count_q == CNW'(MAX_HITS));

	always_comb begin
		for (int i = 0; i < MAX_HITS; i++) begin
			gt[i] = (CNW'(i) < count_q) && ($signed(st_x[i]) > $signed(hx_q));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins && !full) begin
			for (int i = 0; i < MAX_HITS; i++) begin
				if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
					st_x[i] <= st_x[(i > 0) ? i - 1 : 0];
					st_y[i] <= st_y[(i > 0) ? i - 1 : 0];
				end else if (gt[i] || CNW'(i) == count_q) begin
					st_x[i] <= hx_q;
					st_y[i] <= hy_q;
				end
			end
		end
	end

	// polyline state
	assign emit_fire = cmd.emit_load && sts.emit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			rd_q        <= '0;
			have_prev_q <= 1'b0;
			fin_q       <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
		end else begin
			if (in_xfer) begin
				fin_q <= vtx.data.final_vertex;
			end
			if (cmd.ins) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CNW'(1);
				end
			end
			if (cmd.fin) begin
				prev_x_q    <= cur_x_q;
				prev_y_q    <= cur_y_q;
				have_prev_q <= 1'b1;
			end
			if (cmd.emit_load) begin
				rd_q <= rd_q + IW'(1);
			end
			if (emit_fire) begin
				count_q     <= '0;
				ovf_q       <= 1'b0;
				rd_q        <= '0;
				have_prev_q <= 1'b0;
				prev_x_q    <= '0;
				prev_y_q    <= '0;
			end
		end
	end

	// output register
	logic           out_vld_q;
	plcs_pkg::hit_t out_q;
	logic           none;

	assign none          = (count_q == '0);
	assign sts.emit_last = none || ((CNW'(rd_q) + CNW'(1)) == count_q);
	assign sts.out_free  = !out_vld_q || hit.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit_load) begin
			out_vld_q <= 1'b1;
		end else if (hit.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_q.hit_x        <= none ? '0 : FW'($signed(st_x[rd_q]));
			out_q.hit_y        <= none ? '0 : FW'($signed(st_y[rd_q]));
			out_q.last_hit     <= sts.emit_last;
			out_q.none_found   <= none;
			out_q.hits_dropped <= ovf_q;
		end
	end

	assign hit.valid = out_vld_q;
	assign hit.data  = out_q;

	assign sts.in_valid     = vtx.valid;
	assign sts.have_prev    = have_prev_q;
	assign sts.final_vertex = fin_q;

endmodule

`default_nettype wire

FILE: rtl/polyline_line_crossings_sorted.sv
// ----------------------------------------------------------------------------
// polyline_line_crossings_sorted
// Intersects each polyline segment with a fixed cutting segment and emits the
// crossings sorted by x when the polyline ends.
// ----------------------------------------------------------------------------
// The block takes one vertex at a time; each vertex after the first closes a
// segment with the previous one, which is tested against the cutting segment
// in the cut_* registers using exact integer arithmetic (parallel segments
// never hit, endpoints count). One vertex is worked on at a time. Each
// segment takes six products through one shared multiplier; a crossing then
// takes, for each coordinate, two partial products and a restoring divide that
// yields one quotient bit per cycle, then a one-cycle insert into the sorted
// store. On the final vertex the hits follow at one per cycle while the output
// side takes them, ties in arrival order, the last one marked; with no hits a
// single none_found result comes out. Hits beyond MAX_HITS are dropped and
// flagged on every result of that polyline. Write the cut registers only while
// the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_line_crossings_sorted #(
	parameter int MAX_HITS    = plcs_pkg::MAX_HITS_DEF,
	parameter int COORD_WIDTH = plcs_pkg::COORD_WIDTH_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire [plcs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire [plcs_pkg::FIELD_W-1:0]    cfg_data,
	plcs_vtx_if.sink                       vtx,
	plcs_hit_if.source                     hit
);

	// command and status between sequencer and datapath
	plcs_pkg::cmd_t cmd;
	plcs_pkg::sts_t sts;

	plcs_ctrl #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	plcs_dp #(
		.MAX_HITS    (MAX_HITS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.vtx      (vtx),
		.hit      (hit)
	);

endmodule

`default_nettype wire

FILE: bench/tb_polyline_line_crossings_sorted.sv
// ----------------------------------------------------------------------------
// tb_polyline_line_crossings_sorted
// Drives polylines of random and hand-picked vertices into the crossing
// block under several cutting segments, predicts the sorted hit lists with
// exact wide arithmetic, and checks every result transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_polyline_line_crossings_sorted;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NHITS     = plcs_pkg::MAX_HITS_DEF;
	localparam int IDLE_TAIL = 200;
	localparam int WD_LIMIT  = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [plcs_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [plcs_pkg::FIELD_W-1:0] cfg_data = '0;

	plcs_vtx_if vtx ();
	plcs_hit_if hit ();

	polyline_line_crossings_sorted u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .vtx(vtx.sink), .hit(hit.source)
	);

	always #5 clk = ~clk;

	// predictor state: cutting segment, previous vertex and sorted hit store
	logic signed [31:0] cut_cx, cut_cy, cut_dx, cut_dy;
	logic signed [31:0] last_x, last_y;
	logic               seen_prev;
	logic signed [31:0] store_x [NHITS];
	logic signed [31:0] store_y [NHITS];
	int                 store_n;
	logic               store_full;

	plcs_pkg::vtx_t vtx_queue [$];
	plcs_pkg::hit_t hit_expected [$];
	int   errors = 0;
	int   send_idle = 33, recv_idle = 80;
	logic recv_hold = 1'b0;
	logic send_pause = 1'b0;
	logic in_fire = 1'b0;
	int   quiet_cycles = 0;

	task automatic report_mismatch(input string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	// trunc(num*delta/den), num >= 0, den > 0
	function automatic logic signed [31:0] offset_of(input logic signed [127:0] num,
			input logic signed [63:0] delta, input logic signed [127:0] den);
		logic [127:0] mag, q;
		mag = delta[63] ? -delta : delta;
		q = (num * {64'd0, mag}) / den;
		return delta[63] ? -q[31:0] : q[31:0];
	endfunction

	task automatic insert_hit(input logic signed [31:0] x, input logic signed [31:0] y);
		int pos;
		if (store_n >= NHITS) begin
			store_full = 1'b1;
			return;
		end
		pos = 0;
		while (pos < store_n && store_x[pos] <= x) pos++;
		for (int i = store_n; i > pos; i--) begin
			store_x[i] = store_x[i-1];
			store_y[i] = store_y[i-1];
		end
		store_x[pos] = x;
		store_y[pos] = y;
		store_n++;
	endtask

	task automatic test_segment(input logic signed [31:0] ax, input logic signed [31:0] ay,
			input logic signed [31:0] bx, input logic signed [31:0] by);
		logic signed [127:0] dx1, dy1, dx2, dy2, ox, oy, den, na, nb;
		dx1 = 128'(signed'(64'(bx) - 64'(ax)));
		dy1 = 128'(signed'(64'(by) - 64'(ay)));
		dx2 = 128'(signed'(64'(cut_dx) - 64'(cut_cx)));
		dy2 = 128'(signed'(64'(cut_dy) - 64'(cut_cy)));
		ox  = 128'(signed'(64'(ax) - 64'(cut_cx)));
		oy  = 128'(signed'(64'(ay) - 64'(cut_cy)));
		den = dy2*dx1 - dx2*dy1;
		na  = dx2*oy - dy2*ox;
		nb  = dx1*oy - dy1*ox;
		if (den == 0) return;
		if (den < 0) begin
			den = -den; na = -na; nb = -nb;
		end
		if (na < 0 || nb < 0 || den - na < 0 || den - nb < 0) return;
		insert_hit(ax + offset_of(na, 64'(bx) - 64'(ax), den),
			ay + offset_of(na, 64'(by) - 64'(ay), den));
	endtask

	task automatic predict_vertex(input plcs_pkg::vtx_t v);
		plcs_pkg::hit_t r;
		if (seen_prev) test_segment(last_x, last_y, v.vertex_x, v.vertex_y);
		last_x = v.vertex_x;
		last_y = v.vertex_y;
		seen_prev = 1'b1;
		if (!v.final_vertex) return;
		if (store_n == 0) begin
			r = '{hit_x: '0, hit_y: '0, last_hit: 1'b1, none_found: 1'b1,
				hits_dropped: store_full};
			hit_expected.insert(hit_expected.size(), r);
		end else begin
			for (int k = 0; k < store_n; k++) begin
				r = '{hit_x: store_x[k], hit_y: store_y[k], last_hit: k + 1 == store_n,
					none_found: 1'b0, hits_dropped: store_full};
				hit_expected.insert(hit_expected.size(), r);
			end
		end
		seen_prev = 1'b0;
		last_x = '0;
		last_y = '0;
		store_n = 0;
		store_full = 1'b0;
	endtask

	// driver: offer queued vertices, change inputs on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			vtx.valid <= 1'b0;
		end else if (vtx.valid && !in_fire) begin
			// hold the offer until the transfer
		end else if (vtx_queue.size() > 0 && !send_pause && $urandom_range(99) >= send_idle) begin
			vtx.data <= vtx_queue.pop_front();
			vtx.valid <= 1'b1;
		end else begin
			vtx.valid <= 1'b0;
		end
		hit.ready <= arst_n && !recv_hold && $urandom_range(99) >= recv_idle;
	end

	// track the offered vertex so a transfer is predicted once
	always @(posedge clk) begin
		in_fire <= arst_n && vtx.valid && vtx.ready;
		if (arst_n && vtx.valid && vtx.ready) begin
			predict_vertex(vtx.data);
		end
	end

	// monitor: compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		plcs_pkg::hit_t got, want;
		if (arst_n && hit.valid && hit.ready) begin
			got = hit.data;
			if (hit_expected.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", got));
			end else begin
				want = hit_expected.pop_front();
				if (got.hit_x !== want.hit_x)
					report_mismatch($sformatf("hit_x %h want %h", got.hit_x, want.hit_x));
				if (got.hit_y !== want.hit_y)
					report_mismatch($sformatf("hit_y %h want %h", got.hit_y, want.hit_y));
				if (got.last_hit !== want.last_hit)
					report_mismatch($sformatf("last_hit %b want %b", got.last_hit, want.last_hit));
				if (got.none_found !== want.none_found)
					report_mismatch($sformatf("none_found %b want %b", got.none_found,
						want.none_found));
				if (got.hits_dropped !== want.hits_dropped)
					report_mismatch($sformatf("hits_dropped %b want %b", got.hits_dropped,
						want.hits_dropped));
			end
		end
	end

	// watchdog: count cycles without any transfer
	always @(posedge clk) begin
		if ((vtx.valid && vtx.ready) || (hit.valid && hit.ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return $urandom;
			1: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(40)) - 20) <<< 16;
		endcase
	endfunction

	task automatic add_vertex(input logic [31:0] x, input logic [31:0] y, input logic f);
		plcs_pkg::vtx_t v;
		v.vertex_x = x;
		v.vertex_y = y;
		v.final_vertex = f;
		vtx_queue.insert(vtx_queue.size(), v);
	endtask

	task automatic wait_drained();
		while (vtx_queue.size() > 0 || vtx.valid || hit_expected.size() > 0) @(posedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	task automatic write_cut(input logic [plcs_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			plcs_pkg::REG_CUT_START_X: cut_cx = val;
			plcs_pkg::REG_CUT_START_Y: cut_cy = val;
			plcs_pkg::REG_CUT_END_X:   cut_dx = val;
			default:                   cut_dy = val;
		endcase
	endtask

	task automatic set_cut(input logic [31:0] cx, input logic [31:0] cy,
			input logic [31:0] dx, input logic [31:0] dy);
		write_cut(plcs_pkg::REG_CUT_START_X, cx);
		write_cut(plcs_pkg::REG_CUT_START_Y, cy);
		write_cut(plcs_pkg::REG_CUT_END_X, dx);
		write_cut(plcs_pkg::REG_CUT_END_Y, dy);
	endtask

	// random polylines: mostly a few vertices, some long ones to fill the store
	task automatic random_polylines(input int n_items);
		int sent, len;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 36) : $urandom_range(6, 1);
			for (int i = 0; i < len; i++) begin
				if (len > 30)
					add_vertex(32'($signed($urandom_range(20)) - 10) <<< 16,
						(i % 2) ? 32'h0005_0000 : 32'hFFFB_0000, i == len - 1);
				else
					add_vertex(rand_coord(), rand_coord(), i == len - 1);
			end
			sent += len;
		end
	endtask

	initial begin
		cut_cx = '0; cut_cy = '0; cut_dx = '0; cut_dy = '0;
		last_x = '0; last_y = '0; seen_prev = 1'b0; store_n = 0; store_full = 1'b0;
		vtx.valid = 1'b0;
		vtx.data = '0;
		hit.ready = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed: horizontal cut across x from -8 to 8 at y 0
		set_cut(32'hFFF8_0000, 32'h0, 32'h0008_0000, 32'h0);
		add_vertex(32'h1, 32'h2, 1'b1);                      // lone vertex, none found
		add_vertex(32'h0003_0000, 32'hFFFF_0000, 1'b0);      // crossings out of order
		add_vertex(32'h0003_0000, 32'h0001_0000, 1'b0);
		add_vertex(32'hFFFE_0000, 32'hFFFF_0000, 1'b0);
		add_vertex(32'hFFFE_0000, 32'h0001_0000, 1'b0);
		add_vertex(32'h0003_0000, 32'hFFFF_0000, 1'b1);      // tie in x
		add_vertex(32'h0008_0000, 32'h0, 1'b0);              // endpoint touch
		add_vertex(32'h0008_0000, 32'h0003_0000, 1'b0);
		add_vertex(32'h0008_0000, 32'h0003_0000, 1'b0);      // zero length
		add_vertex(32'h0001_0000, 32'h0, 1'b0);              // collinear overlap
		add_vertex(32'h0005_0000, 32'h0, 1'b1);
		add_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);      // extremes
		add_vertex(32'h8000_0000, 32'h8000_0000, 1'b1);
		add_vertex(32'h0001_2345, 32'hFFFF_FFFF, 1'b0);      // fractional hit
		add_vertex(32'hFFFF_0001, 32'h0002_0001, 1'b1);
		add_vertex(32'h0, 32'h0009_0000, 1'b0);              // misses
		add_vertex(32'h0, 32'h0001_0000, 1'b1);
		wait_drained();

		// fill and overflow the store while the receiver holds off
		send_pause = 1'b1;
		for (int i = 0; i < 36; i++)
			add_vertex(32'(i - 18) <<< 14, (i % 2) ? 32'h0001_0000 : 32'hFFFF_0000, i == 35);
		add_vertex(32'h0, 32'h0001_0000, 1'b0);
		add_vertex(32'h0, 32'hFFFF_0000, 1'b1);
		recv_hold = 1'b1;
		send_pause = 1'b0;
		repeat (4000) @(posedge clk);
		recv_hold = 1'b0;
		wait_drained();

		// random phases across several cuts, idling swapped then off
		set_cut(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		random_polylines(50);
		wait_drained();
		send_idle = 80; recv_idle = 33;
		set_cut(32'hFFF6_0000, 32'h0, 32'h000A_0000, 32'h0);
		random_polylines(50);
		wait_drained();
		send_idle = 0; recv_idle = 0;
		set_cut($urandom, $urandom, $urandom, $urandom);
		random_polylines(25);
		wait_drained();
		set_cut(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		random_polylines(25);
		wait_drained();

		if (errors == 0 && hit_expected.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

`default_nettype wire
